/* hw/rtl/i2cms_pkg.sv */
// i2cms_pkg: shared types and constants of the i2c master status sequencer
// used by i2cms_decode and i2c_master_status_sequencer; depends on nothing
package i2cms_pkg;

	// item kind carried on the input tuser
	typedef enum logic [1:0] {
		FN_LOAD   = 2'd0,
		FN_START  = 2'd1,
		FN_STATUS = 2'd2
	} func_t;

	// master phase reported with every result
	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_STARTED   = 3'd1,
		PH_RESTARTED = 3'd2,
		PH_REPSTART  = 3'd3,
		PH_DATA_ACK  = 3'd4,
		PH_DATA_NACK = 3'd5
	} phase_t;

	// controller status codes
	localparam logic [7:0] ST_START       = 8'h08;
	localparam logic [7:0] ST_RESTART     = 8'h10;
	localparam logic [7:0] ST_SLA_W_ACK   = 8'h18;
	localparam logic [7:0] ST_SLA_W_NACK  = 8'h20;
	localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
	localparam logic [7:0] ST_DATA_W_NACK = 8'h30;
	localparam logic [7:0] ST_ARB_LOST    = 8'h38;
	localparam logic [7:0] ST_SLA_R_ACK   = 8'h40;
	localparam logic [7:0] ST_SLA_R_NACK  = 8'h48;
	localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
	localparam logic [7:0] ST_DATA_R_NACK = 8'h58;

	// set request bits
	localparam logic [2:0] SET_START = 3'b001;
	localparam logic [2:0] SET_STOP  = 3'b010;
	localparam logic [2:0] SET_ACK   = 3'b100;
	// clear request bits
	localparam logic [2:0] CLR_SI    = 3'b001;
	localparam logic [2:0] CLR_START = 3'b010;
	localparam logic [2:0] CLR_ACK   = 3'b100;

	// configuration register indexes
	localparam logic CFG_WRITE_LEN = 1'b0;
	localparam logic CFG_READ_LEN  = 1'b1;

	localparam int LEN_W = 5;
	localparam int RX_IDX_W = 4;
	localparam int STORE_MAX = 16;  // load index is 4 bits wide

	// one input item
	typedef struct packed {
		func_t      func;
		logic [3:0] buf_index;
		logic [7:0] buf_byte;
		logic [7:0] status_code;
		logic [7:0] rx_data;
	} item_t;

	// one result item
	typedef struct packed {
		logic                tx_valid;
		logic [7:0]          tx_byte;
		logic [2:0]          set_flags;
		logic [2:0]          clear_flags;
		logic                rx_valid;
		logic [RX_IDX_W-1:0] rx_index;
		logic [7:0]          rx_byte;
		phase_t              master_state;
		logic                end_flag;
	} result_t;

endpackage

/* hw/rtl/i2cms_decode.sv */
// i2cms_decode: status decode and next-state logic for one item
// depends on i2cms_pkg
module i2cms_decode #(
	parameter int BUF_DEPTH = 16,
	parameter int IDX_W = 5
) (
	input  i2cms_pkg::item_t   item,
	input  logic [i2cms_pkg::LEN_W-1:0] write_length,
	input  logic [i2cms_pkg::LEN_W-1:0] read_length,
	input  logic [IDX_W-1:0]   write_index,
	input  logic [IDX_W-1:0]   read_index,
	input  i2cms_pkg::phase_t  phase,
	input  logic               done_flag,
	input  logic [7:0]         tx_rd_byte,   // buffer entry at the send address
	output logic [IDX_W-1:0]   write_index_nx,
	output logic [IDX_W-1:0]   read_index_nx,
	output i2cms_pkg::phase_t  phase_nx,
	output logic               done_flag_nx,
	output i2cms_pkg::result_t result
);

	localparam int CMP_W = (IDX_W > i2cms_pkg::LEN_W) ? IDX_W : i2cms_pkg::LEN_W;
	localparam logic [IDX_W-1:0] DEPTH_V = IDX_W'(BUF_DEPTH);

	logic [IDX_W-1:0] send_idx;
	logic             send_ok;
	logic             send;
	logic             below_wlen;
	logic             rd_ok;
	logic             to_nack;

	// start status rewinds the write index before sending
	assign send_idx = (item.status_code == i2cms_pkg::ST_START) ? '0 : write_index;
	assign send_ok = send_idx < DEPTH_V;
	assign below_wlen = (CMP_W'(write_index) < CMP_W'(write_length)) &&
		(write_index < DEPTH_V);
	assign rd_ok = read_index < DEPTH_V;

	always_comb begin
		write_index_nx = write_index;
		read_index_nx = read_index;
		phase_nx = phase;
		done_flag_nx = done_flag;
		result = '0;
		send = 1'b0;
		to_nack = 1'b0;

		case (item.func)
			i2cms_pkg::FN_LOAD: begin
			end
			i2cms_pkg::FN_START: begin
				write_index_nx = '0;
				read_index_nx = '0;
				phase_nx = i2cms_pkg::PH_IDLE;
				done_flag_nx = 1'b0;
				result.set_flags = i2cms_pkg::SET_START;
			end
			i2cms_pkg::FN_STATUS: begin
				case (item.status_code)
					i2cms_pkg::ST_START: begin
						send = 1'b1;
						result.clear_flags = i2cms_pkg::CLR_SI | i2cms_pkg::CLR_START;
						phase_nx = i2cms_pkg::PH_STARTED;
					end
					i2cms_pkg::ST_RESTART: begin
						read_index_nx = '0;
						send = 1'b1;
						result.clear_flags = i2cms_pkg::CLR_SI | i2cms_pkg::CLR_START;
						phase_nx = i2cms_pkg::PH_RESTARTED;
					end
					i2cms_pkg::ST_SLA_W_ACK: begin
						if (phase == i2cms_pkg::PH_STARTED) begin
							send = 1'b1;
							phase_nx = i2cms_pkg::PH_DATA_ACK;
						end
						result.clear_flags = i2cms_pkg::CLR_SI;
					end
					i2cms_pkg::ST_DATA_W_ACK, i2cms_pkg::ST_DATA_W_NACK: begin
						if (below_wlen) begin
							send = 1'b1;
							phase_nx = i2cms_pkg::PH_DATA_ACK;
						end else if (read_length != '0) begin
							result.set_flags = i2cms_pkg::SET_START;
							phase_nx = i2cms_pkg::PH_REPSTART;
						end else begin
							to_nack = 1'b1;
						end
						result.clear_flags = i2cms_pkg::CLR_SI;
					end
					i2cms_pkg::ST_SLA_R_ACK: begin
						result.set_flags = i2cms_pkg::SET_ACK;
						result.clear_flags = i2cms_pkg::CLR_SI;
					end
					i2cms_pkg::ST_DATA_R_ACK: begin
						if (rd_ok) begin
							result.rx_valid = 1'b1;
							result.rx_index = i2cms_pkg::RX_IDX_W'(read_index);
							result.rx_byte = item.rx_data;
							read_index_nx = read_index + IDX_W'(1);
						end
						result.clear_flags = i2cms_pkg::CLR_ACK | i2cms_pkg::CLR_SI;
					end
					i2cms_pkg::ST_DATA_R_NACK: begin
						if (rd_ok) begin
							result.rx_valid = 1'b1;
							result.rx_index = i2cms_pkg::RX_IDX_W'(read_index);
							result.rx_byte = item.rx_data;
						end
						to_nack = 1'b1;
						result.clear_flags = i2cms_pkg::CLR_SI;
						done_flag_nx = 1'b1;
					end
					i2cms_pkg::ST_SLA_W_NACK, i2cms_pkg::ST_SLA_R_NACK: begin
						to_nack = 1'b1;
						result.clear_flags = i2cms_pkg::CLR_SI;
					end
					i2cms_pkg::ST_ARB_LOST: begin
						result.clear_flags = i2cms_pkg::CLR_SI;
					end
					default: begin
						result.clear_flags = i2cms_pkg::CLR_SI;
					end
				endcase

				// send: byte from the buffer, index saturates at the depth
				if (send) begin
					result.tx_valid = 1'b1;
					if (send_ok) begin
						result.tx_byte = tx_rd_byte;
						write_index_nx = send_idx + IDX_W'(1);
					end else begin
						write_index_nx = send_idx;
					end
				end

				// folded stop request
				if (to_nack) begin
					phase_nx = i2cms_pkg::PH_DATA_NACK;
					result.set_flags = result.set_flags | i2cms_pkg::SET_STOP;
					result.clear_flags = result.clear_flags | i2cms_pkg::CLR_SI;
				end
			end
			default: begin
			end
		endcase

		result.master_state = phase_nx;
		result.end_flag = done_flag_nx;
	end

endmodule

/* hw/rtl/i2c_master_status_sequencer.sv */
// i2c_master_status_sequencer: top level, item register, state, tx buffer, result register
// depends on i2cms_pkg and i2cms_decode
//
// Drives an I2C master controller through a write-then-read transfer. Each input item
// is one of: a load (tuser 0) that writes a byte into the transmit buffer, a start
// (tuser 1) that rewinds the indices, clears the phase and the end flag and asks for
// START, or a status event (tuser 2) that carries the controller status code and the
// data register. For every item exactly one result item comes out, telling software
// or a controller wrapper which byte to load, which START/STOP/ACK bits to set, which
// SI/START/ACK bits to clear, any received byte with its read position, the master
// phase and the end flag. An address NACK, the last read byte, or the end of the
// write with nothing to read also asks for STOP. The block takes one item per clock:
// an item is held in the input register, its decode is a short status case between
// that register and the result register, and the indices and phase are updated as the
// result register loads, so the next item already sees them. Only m_tready low stalls
// the flow, since a held result register also holds the input register and s_tready.
// The transmit buffer is a small register file read at the current write index;
// entries at or above 16 cannot be loaded, since the load index is four bits wide.
// The user must set write_length and read_length from the config port only while the
// block is idle; the block itself does not enforce this.
module i2c_master_status_sequencer #(
	parameter int BUF_DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	// config port
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data,
	// input items
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // buf_index[3:0], buf_byte[11:4], status_code[19:12],
	                               // rx_data[27:20], zero[31:28]
	input  logic [1:0]  s_tuser,   // func
	// result items
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // tx_valid[0], tx_byte[8:1], set_flags[11:9],
	                               // clear_flags[14:12], rx_valid[15], rx_index[19:16],
	                               // rx_byte[27:20], master_state[30:28], end_flag[31]
);

	localparam int IDX_W = $clog2(BUF_DEPTH + 1);
	localparam int STORE = (BUF_DEPTH < i2cms_pkg::STORE_MAX) ? BUF_DEPTH :
		i2cms_pkg::STORE_MAX;
	localparam int SEL_W = $clog2(STORE);
	localparam logic [IDX_W-1:0] STORE_V = IDX_W'(STORE);

	// input register
	logic               valid_s1;
	i2cms_pkg::item_t   item_s1;
	// result register
	logic               out_valid_q;
	i2cms_pkg::result_t result_q;
	// sequencer state
	logic [4:0]         write_length_q;
	logic [4:0]         read_length_q;
	logic [IDX_W-1:0]   write_index_q;
	logic [IDX_W-1:0]   read_index_q;
	i2cms_pkg::phase_t  phase_q;
	logic               done_flag_q;
	// transmit buffer
	logic [7:0]         tx_buffer_q [STORE];

	logic               advance;
	logic [IDX_W-1:0]   rd_addr;
	logic [7:0]         tx_rd_byte;
	logic [IDX_W-1:0]   write_index_nx;
	logic [IDX_W-1:0]   read_index_nx;
	i2cms_pkg::phase_t  phase_nx;
	logic               done_flag_nx;
	i2cms_pkg::result_t result_nx;
	logic               load_hit;

	// the input register moves on whenever the result register is free or drains
	assign advance = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.func <= i2cms_pkg::func_t'(s_tuser);
			item_s1.buf_index <= s_tdata[3:0];
			item_s1.buf_byte <= s_tdata[11:4];
			item_s1.status_code <= s_tdata[19:12];
			item_s1.rx_data <= s_tdata[27:20];
		end
	end

	// send address: start status reads entry zero, others the write index
	assign rd_addr = (item_s1.status_code == i2cms_pkg::ST_START) ? '0 : write_index_q;
	// entries the load port cannot reach read as zero
	assign tx_rd_byte = (rd_addr < STORE_V) ? tx_buffer_q[SEL_W'(rd_addr)] : 8'h00;

	// load into the buffer; an index past the depth is dropped
	assign load_hit = advance && (item_s1.func == i2cms_pkg::FN_LOAD) &&
		(5'(item_s1.buf_index) < 5'(STORE));

	always_ff @(posedge clk) begin
		if (load_hit) begin
			tx_buffer_q[SEL_W'(item_s1.buf_index)] <= item_s1.buf_byte;
		end
	end

	i2cms_decode #(
		.BUF_DEPTH (BUF_DEPTH),
		.IDX_W     (IDX_W)
	) u_decode (
		.item           (item_s1),
		.write_length   (write_length_q),
		.read_length    (read_length_q),
		.write_index    (write_index_q),
		.read_index     (read_index_q),
		.phase          (phase_q),
		.done_flag      (done_flag_q),
		.tx_rd_byte     (tx_rd_byte),
		.write_index_nx (write_index_nx),
		.read_index_nx  (read_index_nx),
		.phase_nx       (phase_nx),
		.done_flag_nx   (done_flag_nx),
		.result         (result_nx)
	);

	// config registers and sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_length_q <= 5'd2;
			read_length_q <= 5'd2;
			write_index_q <= '0;
			read_index_q <= '0;
			phase_q <= i2cms_pkg::PH_IDLE;
			done_flag_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					i2cms_pkg::CFG_WRITE_LEN: write_length_q <= cfg_data;
					i2cms_pkg::CFG_READ_LEN: read_length_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (advance) begin
				write_index_q <= write_index_nx;
				read_index_q <= read_index_nx;
				phase_q <= phase_nx;
				done_flag_q <= done_flag_nx;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_nx;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {result_q.end_flag, result_q.master_state, result_q.rx_byte,
		result_q.rx_index, result_q.rx_valid, result_q.clear_flags, result_q.set_flags,
		result_q.tx_byte, result_q.tx_valid};

endmodule

/* test/i2c_master_status_sequencer_tb.sv */
// i2c_master_status_sequencer_tb: self-checking bench for the i2c master status sequencer
// needs i2cms_pkg and the sequencer rtl; a local predictor checks every reply item
module i2c_master_status_sequencer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import i2cms_pkg::*;

	localparam int PERIOD    = 10;
	localparam int DEPTH     = 16;
	localparam int SETTLE    = 8;       // settling margin after the block has drained
	localparam int LIMIT     = 400000;  // cycle budget for the whole run
	localparam int PER_PHASE = 100;     // random items per length setting
	localparam int N_PHASES  = 12;
	localparam int MAX_SHOWN = 10;

	// func code outside the enum, the block must leave its state alone
	localparam logic [1:0] FN_UNKNOWN = 2'd3;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        cfg_we   = 1'b0;
	logic        cfg_index = 1'b0;
	logic [4:0]  cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata  = '0;  // buf_index[3:0], buf_byte[11:4], status_code[19:12],
	                             // rx_data[27:20], zero[31:28]
	logic [1:0]  s_tuser  = '0;  // func
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;        // tx_valid[0], tx_byte[8:1], set_flags[11:9],
	                             // clear_flags[14:12], rx_valid[15], rx_index[19:16],
	                             // rx_byte[27:20], master_state[30:28], end_flag[31]

	i2c_master_status_sequencer uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #(PERIOD/2) clk = ~clk;

	// items waiting for the driver, and replies the block still owes us
	item_t   item_q[$];
	result_t reply_q[$];

	// idle percentages for the sender and the receiver side
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	int gen_cnt     = 0;
	int xfer_cnt    = 0;
	int cfg_cnt     = 0;
	int checked_cnt = 0;
	int fail_cnt    = 0;
	int cycle_cnt   = 0;

	// predictor's own copy of the sequencer state and length registers
	logic [7:0] tx_store [DEPTH];
	logic [4:0] wr_pos   = '0;   // runs up to DEPTH, one bit wider than the buffer index
	logic [4:0] rd_pos   = '0;
	phase_t     ph_now   = PH_IDLE;
	logic       done_now = 1'b0;
	logic [4:0] len_write = 5'd2;
	logic [4:0] len_read  = 5'd2;

	item_t sent_item;  // the item currently offered on the input side

	// next transmit byte, write position saturates at the buffer depth
	function automatic logic [7:0] pop_tx_byte();
		logic [7:0] b;
		b = '0;
		if (wr_pos < DEPTH) begin
			b = tx_store[wr_pos[3:0]];
			wr_pos++;
		end
		return b;
	endfunction

	// reply of the sequencer to one item, advancing the predicted state
	function automatic result_t sequencer_reply(item_t it);
		result_t    r;
		logic [4:0] wlen;
		logic       to_nack;
		r = '0;
		to_nack = 1'b0;
		wlen = (len_write > DEPTH) ? 5'(DEPTH) : len_write;
		case (it.func)
			FN_LOAD: begin
				tx_store[it.buf_index] = it.buf_byte;
			end
			FN_START: begin
				wr_pos = '0;
				rd_pos = '0;
				ph_now = PH_IDLE;
				done_now = 1'b0;
				r.set_flags = SET_START;
			end
			FN_STATUS: begin
				case (it.status_code)
					ST_START: begin
						wr_pos = '0;
						r.tx_valid = 1'b1;
						r.tx_byte = pop_tx_byte();
						r.clear_flags = CLR_SI | CLR_START;
						ph_now = PH_STARTED;
					end
					ST_RESTART: begin
						rd_pos = '0;
						r.tx_valid = 1'b1;
						r.tx_byte = pop_tx_byte();
						r.clear_flags = CLR_SI | CLR_START;
						ph_now = PH_RESTARTED;
					end
					ST_SLA_W_ACK: begin
						// only the address phase of the write sends the first data byte
						if (ph_now == PH_STARTED) begin
							r.tx_valid = 1'b1;
							r.tx_byte = pop_tx_byte();
							ph_now = PH_DATA_ACK;
						end
						r.clear_flags = CLR_SI;
					end
					ST_DATA_W_ACK, ST_DATA_W_NACK: begin
						if (wr_pos < wlen) begin
							r.tx_valid = 1'b1;
							r.tx_byte = pop_tx_byte();
							ph_now = PH_DATA_ACK;
						end else if (len_read != 0) begin
							r.set_flags = SET_START;
							ph_now = PH_REPSTART;
						end else begin
							to_nack = 1'b1;
						end
						r.clear_flags = CLR_SI;
					end
					ST_SLA_R_ACK: begin
						r.set_flags = SET_ACK;
						r.clear_flags = CLR_SI;
					end
					ST_DATA_R_ACK: begin
						// bytes past the read buffer are dropped
						if (rd_pos < DEPTH) begin
							r.rx_valid = 1'b1;
							r.rx_index = rd_pos[3:0];
							r.rx_byte = it.rx_data;
							rd_pos++;
						end
						r.clear_flags = CLR_ACK | CLR_SI;
					end
					ST_DATA_R_NACK: begin
						if (rd_pos < DEPTH) begin
							r.rx_valid = 1'b1;
							r.rx_index = rd_pos[3:0];
							r.rx_byte = it.rx_data;
						end
						to_nack = 1'b1;
						r.clear_flags = CLR_SI;
						done_now = 1'b1;
					end
					ST_SLA_W_NACK, ST_SLA_R_NACK: begin
						to_nack = 1'b1;
						r.clear_flags = CLR_SI;
					end
					default: begin
						// arbitration lost and unknown codes just release SI
						r.clear_flags = CLR_SI;
					end
				endcase
				// folded-in stop call
				if (to_nack) begin
					ph_now = PH_DATA_NACK;
					r.set_flags = r.set_flags | SET_STOP;
					r.clear_flags = r.clear_flags | CLR_SI;
				end
			end
			default: ;
		endcase
		r.master_state = ph_now;
		r.end_flag = done_now;
		return r;
	endfunction

	function automatic string fmt_reply(result_t r);
		return $sformatf("txv=%0d txb=%02h set=%b clr=%b rxv=%0d rxi=%0d rxb=%02h st=%0d end=%0d",
			r.tx_valid, r.tx_byte, r.set_flags, r.clear_flags, r.rx_valid, r.rx_index,
			r.rx_byte, r.master_state, r.end_flag);
	endfunction

	task automatic note_failure(string msg);
		fail_cnt++;
		if (fail_cnt <= MAX_SHOWN)
			$display("%s", msg);
	endtask

	// compare one reply item from the block with the oldest prediction
	task automatic check_reply(logic [31:0] d);
		result_t    got;
		result_t    want;
		logic [8:0] bad;
		got.tx_valid     = d[0];
		got.tx_byte      = d[8:1];
		got.set_flags    = d[11:9];
		got.clear_flags  = d[14:12];
		got.rx_valid     = d[15];
		got.rx_index     = d[19:16];
		got.rx_byte      = d[27:20];
		got.master_state = phase_t'(d[30:28]);
		got.end_flag     = d[31];
		checked_cnt++;
		if (reply_q.size() == 0) begin
			note_failure($sformatf("unexpected reply: %s", fmt_reply(got)));
		end else begin
			want = reply_q.pop_front();
			bad = {got.tx_valid != want.tx_valid, got.tx_byte != want.tx_byte,
				got.set_flags != want.set_flags, got.clear_flags != want.clear_flags,
				got.rx_valid != want.rx_valid, got.rx_index != want.rx_index,
				got.rx_byte != want.rx_byte, got.master_state != want.master_state,
				got.end_flag != want.end_flag};
			if (|bad)
				note_failure($sformatf("reply %0d mismatch (fields %b)\n  want %s\n  got  %s",
					checked_cnt, bad, fmt_reply(want), fmt_reply(got)));
		end
	endtask

	// driver: offers queued items, predicts each one as it is taken
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				reply_q.push_back(sequencer_reply(sent_item));
			// the slot is free when nothing is offered or the offer was just taken
			if (!s_tvalid || s_tready) begin
				if (item_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					sent_item = item_q.pop_front();
					s_tdata <= {4'b0000, sent_item.rx_data, sent_item.status_code,
						sent_item.buf_byte, sent_item.buf_index};
					s_tuser <= sent_item.func;
					s_tvalid <= 1'b1;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: takes reply items with random back-pressure
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready)
				check_reply(m_tdata);
			m_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// item with random content apart from the kind and the status code
	function automatic item_t rand_item(logic [1:0] fn, logic [7:0] code);
		item_t it;
		it.func        = func_t'(fn);
		it.buf_index   = 4'($urandom);
		it.buf_byte    = 8'($urandom);
		it.status_code = code;
		it.rx_data     = 8'($urandom);
		return it;
	endfunction

	task automatic queue_item(item_t it);
		item_q.push_back(it);
		gen_cnt++;
	endtask

	task automatic queue_status(logic [7:0] code);
		queue_item(rand_item(FN_STATUS, code));
	endtask

	// a well-formed write-then-read transfer for the given lengths, with
	// occasional address nacks and overlong reads
	task automatic queue_transfer(int wl, int rl);
		int eff_wl;
		int n_data;
		int extra;
		eff_wl = (wl > DEPTH) ? DEPTH : wl;
		xfer_cnt++;
		queue_item(rand_item(FN_START, 8'($urandom)));
		queue_status(ST_START);
		if ($urandom_range(9) == 0) begin
			queue_status(ST_SLA_W_NACK);
			return;
		end
		queue_status(ST_SLA_W_ACK);
		// address plus first byte went out, the last data ack asks for the restart, or the stop with no read
		n_data = ((eff_wl > 2) ? eff_wl - 2 : 0) + 1;
		repeat (n_data)
			queue_status(($urandom_range(4) == 0) ? ST_DATA_W_NACK : ST_DATA_W_ACK);
		if (rl == 0)
			return;
		queue_status(ST_RESTART);
		if ($urandom_range(9) == 0) begin
			queue_status(ST_SLA_R_NACK);
			return;
		end
		queue_status(ST_SLA_R_ACK);
		// sometimes read beyond the buffer to hit the saturating read index
		extra = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0;
		repeat (rl - 1 + extra)
			queue_status(ST_DATA_R_ACK);
		queue_status(ST_DATA_R_NACK);
	endtask

	// wait until the block has nothing pending, then let it settle
	task automatic wait_drained();
		while (item_q.size() != 0 || s_tvalid || reply_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// both length registers, written back to back while the block is idle
	task automatic write_lengths(logic [4:0] wl, logic [4:0] rl);
		cfg_we <= 1'b1;
		cfg_index <= CFG_WRITE_LEN;
		cfg_data <= wl;
		@(posedge clk);
		cfg_index <= CFG_READ_LEN;
		cfg_data <= rl;
		@(posedge clk);
		cfg_we <= 1'b0;
		len_write = wl;
		len_read = rl;
		cfg_cnt++;
		@(posedge clk);
	endtask

	// global cycle budget
	initial begin
		while (cycle_cnt < LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		item_t it;
		int    wl;
		int    rl;
		int    target;
		int    pick;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part under the reset lengths, sender 20% / receiver 68% idle
		send_idle_pct = 20;
		recv_idle_pct = 68;
		// fill every buffer entry first so no send reads an unwritten one
		for (int i = 0; i < DEPTH; i++) begin
			it = rand_item(FN_LOAD, 8'($urandom));
			it.buf_index = 4'(i);
			if (i == 0)
				it.buf_byte = 8'h00;
			else if (i == DEPTH - 1)
				it.buf_byte = 8'hFF;
			queue_item(it);
		end
		queue_item(rand_item(FN_START, 8'h00));
		queue_status(ST_START);
		queue_status(ST_SLA_W_ACK);
		queue_status(ST_DATA_W_ACK);     // write length reached, asks for repeated start
		queue_status(ST_RESTART);
		queue_status(ST_SLA_R_ACK);
		it = rand_item(FN_STATUS, ST_DATA_R_ACK);
		it.rx_data = 8'h00;
		queue_item(it);
		it = rand_item(FN_STATUS, ST_DATA_R_NACK);
		it.rx_data = 8'hFF;
		queue_item(it);                  // last byte, stop and end flag
		queue_item(rand_item(FN_UNKNOWN, 8'hFF));
		queue_status(ST_ARB_LOST);
		queue_status(ST_SLA_W_NACK);
		queue_status(ST_SLA_R_NACK);
		queue_status(ST_DATA_W_NACK);
		queue_item(rand_item(FN_START, 8'h00));
		queue_status(ST_SLA_W_ACK);      // address ack outside the started phase sends nothing
		wait_drained();

		// random part: one length setting per phase, the sender pauses
		// until all replies are in before each setting changes
		for (int p = 0; p < N_PHASES; p++) begin
			if (p < 4) begin
				send_idle_pct = 20;
				recv_idle_pct = 68;
			end else if (p < 8) begin
				send_idle_pct = 68;
				recv_idle_pct = 20;
			end else begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			case (p % 6)
				0: begin wl = DEPTH; rl = DEPTH; end
				1: begin wl = 0;     rl = 0;     end
				2: begin wl = 31;    rl = 1;     end  // beyond the buffer, acts as full depth
				3: begin wl = 1;     rl = 31;    end
				default: begin
					wl = $urandom_range(0, DEPTH);
					rl = $urandom_range(0, DEPTH);
				end
			endcase
			write_lengths(5'(wl), 5'(rl));
			target = gen_cnt + PER_PHASE;
			while (gen_cnt < target) begin
				pick = $urandom_range(99);
				if (pick < 70) begin
					queue_transfer(wl, rl);
				end else if (pick < 85) begin
					repeat ($urandom_range(1, 3))
						queue_item(rand_item(FN_LOAD, 8'($urandom)));
				end else begin
					// noise: any kind, any status code
					queue_item(rand_item(2'($urandom_range(0, 3)), 8'($urandom)));
				end
			end
			wait_drained();
		end

		$display("covered %0d items in %0d transfers over %0d length settings and three idle mixes",
			gen_cnt, xfer_cnt, cfg_cnt + 1);
		$display("%0d replies checked, %0d failures", checked_cnt, fail_cnt);
		if (fail_cnt == 0 && reply_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
